// ===== rtl/cgm_pkg.sv =====
// Shared types, constants and tables for the color gradient pipeline.
`default_nettype none
package cgm_pkg;

  localparam int unsigned NUM_CH          = 3;
  localparam int unsigned CORDIC_STEPS    = 16;
  localparam int unsigned STEPS_PER_STAGE = 2;
  localparam int unsigned ITER_STAGES     = CORDIC_STEPS / STEPS_PER_STAGE;
  localparam int unsigned SQRT_STAGES     = 7;
  // Gradient (3) + prep (1) + iterations (8) + output register (1).
  localparam int unsigned PIPE_DEPTH      = 3 + 1 + ITER_STAGES + 1;

  typedef logic signed [10:0] grad_t;
  typedef logic [19:0]        mag2_t;

  typedef struct packed {
    logic signed [27:0] x;
    logic signed [27:0] y;
    logic signed [25:0] z;
    logic               gy_zero;
    logic               gx_zero;
    logic               gx_neg;
    logic               gy_pos;
  } cordic_t;

  typedef struct packed {
    logic [27:0] v;
    logic [15:0] rem;
    logic [13:0] root;
  } sqrt_t;

  // atan(2^-i) with pi = 2^23, rounded to nearest.
  function automatic logic [21:0] atan_lut(input int unsigned i);
    logic [21:0] r;
    unique case (i)
      0:  r = 22'd2097152;
      1:  r = 22'd1238021;
      2:  r = 22'd654136;
      3:  r = 22'd332050;
      4:  r = 22'd166669;
      5:  r = 22'd83416;
      6:  r = 22'd41718;
      7:  r = 22'd20860;
      8:  r = 22'd10430;
      9:  r = 22'd5215;
      10: r = 22'd2608;
      11: r = 22'd1304;
      12: r = 22'd652;
      13: r = 22'd326;
      14: r = 22'd163;
      15: r = 22'd81;
      default: r = 22'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/cgm_grad.sv =====
// Per-channel differences, squared magnitudes and max-channel selection (three stages).
`default_nettype none
module cgm_grad
  import cgm_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [23:0] left_pixel_i,
  input  wire logic [23:0] right_pixel_i,
  input  wire logic [23:0] top_pixel_i,
  input  wire logic [23:0] bottom_pixel_i,
  input  wire logic        at_border_i,
  output grad_t            bx_o,
  output grad_t            by_o,
  output mag2_t            m2_o
);

  grad_t gx1_q [NUM_CH];
  grad_t gy1_q [NUM_CH];
  grad_t gx2_q [NUM_CH];
  grad_t gy2_q [NUM_CH];
  mag2_t m22_q [NUM_CH];
  grad_t bx_q, by_q;
  mag2_t m2_q;

  for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
    logic signed [8:0]  dx, dy;
    logic signed [21:0] sx, sy;
    assign dx = $signed({1'b0, right_pixel_i[8*c +: 8]}) - $signed({1'b0, left_pixel_i[8*c +: 8]});
    assign dy = $signed({1'b0, bottom_pixel_i[8*c +: 8]}) - $signed({1'b0, top_pixel_i[8*c +: 8]});
    assign sx = gx1_q[c] * gx1_q[c];
    assign sy = gy1_q[c] * gy1_q[c];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        gx1_q[c] <= at_border_i ? {dx[8], dx, 1'b0} : {{2{dx[8]}}, dx};
        gy1_q[c] <= at_border_i ? {dy[8], dy, 1'b0} : {{2{dy[8]}}, dy};
        gx2_q[c] <= gx1_q[c];
        gy2_q[c] <= gy1_q[c];
        m22_q[c] <= mag2_t'(sx[19:0] + sy[19:0]);
      end
    end
  end

  // The lowest channel wins on a tie; all-zero leaves a zero gradient.
  grad_t bx_d, by_d;
  mag2_t m2_d;
  always_comb begin
    bx_d = '0;
    by_d = '0;
    m2_d = '0;
    for (int c = 0; c < NUM_CH; c++) begin
      if (m22_q[c] > m2_d) begin
        m2_d = m22_q[c];
        bx_d = gx2_q[c];
        by_d = gy2_q[c];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      bx_q <= bx_d;
      by_q <= by_d;
      m2_q <= m2_d;
    end
  end

  assign bx_o = bx_q;
  assign by_o = by_q;
  assign m2_o = m2_q;

endmodule
`default_nettype wire

// ===== rtl/cgm_sqrt.sv =====
// Pipelined digit-by-digit integer square root, two result bits per stage; the last stage only passes the result on.
`default_nettype none
module cgm_sqrt
  import cgm_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  en_i,
  input  mag2_t      m2_i,
  output logic [13:0] root_o
);

  sqrt_t st_q [ITER_STAGES+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0].v    <= {m2_i, 8'd0};
      st_q[0].rem  <= '0;
      st_q[0].root <= '0;
    end
  end

  for (genvar k = 1; k <= ITER_STAGES; k++) begin : g_stage
    sqrt_t st_d;
    always_comb begin
      logic [17:0] rem_t;
      logic [17:0] trial;
      st_d = st_q[k-1];
      if (k <= SQRT_STAGES) begin
        for (int j = 0; j < 2; j++) begin
          rem_t = {st_d.rem, st_d.v[27:26]};
          trial = {2'b00, st_d.root, 2'b01};
          st_d.v = {st_d.v[25:0], 2'b00};
          if (rem_t >= trial) begin
            st_d.rem  = 16'(rem_t - trial);
            st_d.root = {st_d.root[12:0], 1'b1};
          end else begin
            st_d.rem  = rem_t[15:0];
            st_d.root = {st_d.root[12:0], 1'b0};
          end
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[k] <= st_d;
      end
    end
  end

  assign root_o = st_q[ITER_STAGES].root;

endmodule
`default_nettype wire

// ===== rtl/cgm_cordic.sv =====
// Pipelined vectoring CORDIC for atan2, two iterations per stage.
`default_nettype none
module cgm_cordic
  import cgm_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic en_i,
  input  grad_t     gx_i,
  input  grad_t     gy_i,
  output cordic_t   res_o
);

  cordic_t st_q [ITER_STAGES+1];

  // Left half-plane vectors are mirrored and start from +/-pi.
  cordic_t prep_d;
  always_comb begin
    logic signed [27:0] xin, yin;
    xin = {gx_i[10], gx_i, 16'd0};
    yin = {gy_i[10], gy_i, 16'd0};
    prep_d.gy_zero = (gy_i == '0);
    prep_d.gx_zero = (gx_i == '0);
    prep_d.gx_neg  = gx_i[10];
    prep_d.gy_pos  = !gy_i[10] && (gy_i != '0);
    if (gx_i[10]) begin
      prep_d.x = -xin;
      prep_d.y = -yin;
      prep_d.z = prep_d.gy_pos ? 26'sd8388608 : -26'sd8388608;
    end else begin
      prep_d.x = xin;
      prep_d.y = yin;
      prep_d.z = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0] <= prep_d;
    end
  end

  for (genvar k = 1; k <= ITER_STAGES; k++) begin : g_stage
    cordic_t st_d;
    always_comb begin
      logic signed [27:0] xs, ys;
      logic signed [25:0] a;
      st_d = st_q[k-1];
      for (int j = 0; j < STEPS_PER_STAGE; j++) begin
        xs = st_d.x >>> (STEPS_PER_STAGE*(k-1) + j);
        ys = st_d.y >>> (STEPS_PER_STAGE*(k-1) + j);
        a  = $signed({4'd0, atan_lut(STEPS_PER_STAGE*(k-1) + j)});
        if (st_d.y > 0) begin
          st_d.x = st_d.x + ys;
          st_d.y = st_d.y - xs;
          st_d.z = st_d.z + a;
        end else begin
          st_d.x = st_d.x - ys;
          st_d.y = st_d.y + xs;
          st_d.z = st_d.z - a;
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[k] <= st_d;
      end
    end
  end

  assign res_o = st_q[ITER_STAGES];

endmodule
`default_nettype wire

// ===== rtl/color_gradient_magnitude_orientation_top.sv =====
// Top level: max-channel color gradient magnitude and orientation pipeline.
// Each accepted input beat passes the gradient, prep, iteration and output registers in order.
// Throughput: one beat per cycle while the output beat is not stalled; the whole
// pipeline, input included, holds while a valid output beat is stalled.
// Reset clears only the valid bits; data registers are not reset.
`default_nettype none
module color_gradient_magnitude_orientation_top
  import cgm_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  output logic                    stall_o,
  input  wire logic [23:0]        left_pixel_i,
  input  wire logic [23:0]        right_pixel_i,
  input  wire logic [23:0]        top_pixel_i,
  input  wire logic [23:0]        bottom_pixel_i,
  input  wire logic               at_border_i,
  output logic                    valid_o,
  input  wire logic               stall_i,
  output logic [13:0]             magnitude_o,
  output logic signed [15:0]      orientation_o
);

  logic [PIPE_DEPTH-1:0] vld_q;
  logic                  en;
  grad_t                 bx, by;
  mag2_t                 m2;
  logic [13:0]           root;
  cordic_t               cres;
  logic [13:0]           mag_q;
  logic signed [15:0]    ori_q;
  logic signed [15:0]    ori_d;

  assign en      = !vld_q[PIPE_DEPTH-1] || !stall_i;
  assign stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PIPE_DEPTH-2:0], valid_i};
    end
  end

  cgm_grad u_grad (
    .clk_i          (clk_i),
    .en_i           (en),
    .left_pixel_i   (left_pixel_i),
    .right_pixel_i  (right_pixel_i),
    .top_pixel_i    (top_pixel_i),
    .bottom_pixel_i (bottom_pixel_i),
    .at_border_i    (at_border_i),
    .bx_o           (bx),
    .by_o           (by),
    .m2_o           (m2)
  );

  cgm_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .m2_i   (m2),
    .root_o (root)
  );

  cgm_cordic u_cordic (
    .clk_i (clk_i),
    .en_i  (en),
    .gx_i  (bx),
    .gy_i  (by),
    .res_o (cres)
  );

  // Axis directions are exact; otherwise round the angle to 16 bits.
  always_comb begin
    logic signed [25:0] zr;
    zr = cres.z + 26'sd128;
    if (cres.gy_zero) begin
      ori_d = cres.gx_neg ? -16'sd32768 : 16'sd0;
    end else if (cres.gx_zero) begin
      ori_d = cres.gy_pos ? 16'sd16384 : -16'sd16384;
    end else begin
      ori_d = zr[23:8];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mag_q <= root;
      ori_q <= ori_d;
    end
  end

  assign valid_o       = vld_q[PIPE_DEPTH-1];
  assign magnitude_o   = mag_q;
  assign orientation_o = ori_q;

endmodule
`default_nettype wire
